@@ src/reliable_receiver_reorder_buffer_top_assert.svh @@
// Assertion macros shared by the reorder buffer RTL.
`ifndef RELIABLE_RECEIVER_REORDER_BUFFER_TOP_ASSERT_SVH
`define RELIABLE_RECEIVER_REORDER_BUFFER_TOP_ASSERT_SVH

// Clocked check that is masked while reset is high.
`define RRRB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds during reset.
`define RRRB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ src/rrrb_pkg.sv @@
// Shared types and constants of the reorder buffer receiver.
package rrrb_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int MAX_SEGMENT = 4000;
   localparam int TAG_WIDTH   = 8;
   localparam int SEQ_WIDTH   = 32;
   localparam int SIZE_W      = 12;
   localparam int CMD_W       = 3;
   localparam int KIND_W      = 3;
   localparam int SLOT_DATA_W = SEQ_WIDTH + SIZE_W + TAG_WIDTH;

   localparam logic [CMD_W-1:0] CMD_SYN  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DATA = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FIN  = 3'd4;

   localparam logic [KIND_W-1:0] K_DELIVER = 3'd0;
   localparam logic [KIND_W-1:0] K_DISCARD = 3'd1;
   localparam logic [KIND_W-1:0] K_SYNACK  = 3'd2;
   localparam logic [KIND_W-1:0] K_ACK     = 3'd3;
   localparam logic [KIND_W-1:0] K_FINACK  = 3'd4;

   typedef enum logic [1:0] {PH_WAIT, PH_DATA, PH_DONE} phase_type;

   typedef enum logic [2:0] {
      OP_NONE, OP_SYNACK, OP_DISCARD_ONLY, OP_DISCARD_ACK, OP_STORE, OP_DELIVER, OP_FIN
   } op_type;

   typedef enum logic [1:0] {B_IDLE, B_ADDR, B_DATA, B_CLOSE} back_state_type;

   typedef enum logic [1:0] {SC_DRAIN, SC_STALE, SC_FIN} scan_mode_type;

   typedef struct packed {
      op_type                 op;
      logic [SEQ_WIDTH-1:0]   seq;
      logic [SIZE_W-1:0]      size;
      logic [TAG_WIDTH-1:0]   tag;
      logic [SLOT_W-1:0]      slot;
      logic                   ovf;
   } entry_type;

   typedef struct packed {
      phase_type              phase;
      logic [SEQ_WIDTH-1:0]   expected;
      logic                   full;
      logic [SLOT_W-1:0]      free_slot;
      logic                   busy;
   } status_type;

   typedef struct packed {
      logic                   valid;
      logic [KIND_W-1:0]      kind;
      logic [SEQ_WIDTH-1:0]   ack;
      logic [TAG_WIDTH-1:0]   tag;
      logic [SIZE_W-1:0]      size;
      logic                   ovf;
      logic                   last;
   } rsp_type;

endpackage

@@ src/rrrb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rrrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/rrrb_front.sv @@
// Front end: captures a packet beat and classifies it against the receiver state.
module rrrb_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [rrrb_pkg::CMD_W-1:0]     cmd,
   input  logic [rrrb_pkg::SEQ_WIDTH-1:0] seq_number,
   input  logic [rrrb_pkg::SIZE_W-1:0]    payload_size,
   input  logic [rrrb_pkg::TAG_WIDTH-1:0] payload_tag,
   input  rrrb_pkg::status_type           status,
   output logic                           push,
   output rrrb_pkg::entry_type            entry,
   output logic                           busy
);

   logic                           valid_ff;
   logic [rrrb_pkg::CMD_W-1:0]     cmd_ff;
   logic [rrrb_pkg::SEQ_WIDTH-1:0] seq_ff;
   logic [rrrb_pkg::SIZE_W-1:0]    size_ff;
   logic [rrrb_pkg::TAG_WIDTH-1:0] tag_ff;
   rrrb_pkg::op_type               op;
   logic                           ovf;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
      if (accept) begin
         cmd_ff  <= cmd;
         seq_ff  <= seq_number;
         size_ff <= payload_size;
         tag_ff  <= payload_tag;
      end
   end

   always_comb begin
      op  = rrrb_pkg::OP_NONE;
      ovf = 1'b0;
      case (status.phase)
         rrrb_pkg::PH_WAIT: begin
            if (cmd_ff == rrrb_pkg::CMD_SYN) begin
               op = rrrb_pkg::OP_SYNACK;
            end else if (cmd_ff == rrrb_pkg::CMD_DATA) begin
               op = rrrb_pkg::OP_DISCARD_ONLY;
            end
         end
         rrrb_pkg::PH_DATA: begin
            if (cmd_ff == rrrb_pkg::CMD_FIN) begin
               op = rrrb_pkg::OP_FIN;
            end else if (cmd_ff == rrrb_pkg::CMD_DATA) begin
               if ((size_ff > rrrb_pkg::SIZE_W'(rrrb_pkg::MAX_SEGMENT)) ||
                   (seq_ff < status.expected)) begin
                  op = rrrb_pkg::OP_DISCARD_ACK;
               end else if (seq_ff > status.expected) begin
                  if (status.full) begin
                     op  = rrrb_pkg::OP_DISCARD_ACK;
                     ovf = 1'b1;
                  end else begin
                     op = rrrb_pkg::OP_STORE;
                  end
               end else begin
                  op = rrrb_pkg::OP_DELIVER;
               end
            end
         end
         default: begin
            if (cmd_ff == rrrb_pkg::CMD_DATA) begin
               op = rrrb_pkg::OP_DISCARD_ONLY;
            end
         end
      endcase
   end

   assign push       = valid_ff && (op != rrrb_pkg::OP_NONE);
   assign entry.op   = op;
   assign entry.seq  = seq_ff;
   assign entry.size = size_ff;
   assign entry.tag  = tag_ff;
   assign entry.slot = status.free_slot;
   assign entry.ovf  = ovf;
   assign busy       = valid_ff;

endmodule

@@ src/rrrb_queue.sv @@
// Two-entry queue of classified commands between the front and back ends.
module rrrb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rrrb_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                not_empty,
   output rrrb_pkg::entry_type head
);

   rrrb_pkg::entry_type entries_ff [2];
   logic                wr_ptr_ff;
   logic                rd_ptr_ff;
   logic [1:0]          count_ff;
   logic [1:0]          count_in;
   logic                do_push;
   logic                do_pop;

   assign do_push = push && (count_ff != 2'd2);
   assign do_pop  = pop && (count_ff != 2'd0);

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign not_empty = (count_ff != 2'd0);
   assign head      = entries_ff[rd_ptr_ff];

endmodule

@@ src/rrrb_back.sv @@
// Back end: executes commands, walks the reorder slots and emits result beats.
module rrrb_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  rrrb_pkg::entry_type q_head,
   output logic                pop,
   output rrrb_pkg::status_type status,
   output rrrb_pkg::rsp_type   rsp
);

   rrrb_pkg::back_state_type       state_ff, state_in;
   rrrb_pkg::scan_mode_type        mode_ff, mode_in;
   rrrb_pkg::phase_type            phase_ff, phase_in;
   logic [rrrb_pkg::SEQ_WIDTH-1:0] exp_ff, exp_in;
   logic [rrrb_pkg::QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic [rrrb_pkg::SLOT_W-1:0]    idx_ff, idx_in;
   logic                           close_fin_ff, close_fin_in;
   rrrb_pkg::rsp_type              rsp_ff, rsp_in;

   logic                           ram_wr_en;
   logic [rrrb_pkg::SLOT_DATA_W-1:0] ram_wr_data;
   logic                           ram_rd_en;
   logic [rrrb_pkg::SLOT_DATA_W-1:0] ram_rd_data;
   logic [rrrb_pkg::SEQ_WIDTH-1:0] rd_seq;
   logic [rrrb_pkg::SIZE_W-1:0]    rd_size;
   logic [rrrb_pkg::TAG_WIDTH-1:0] rd_tag;
   logic                           scan_end;
   logic                           hit;
   logic [rrrb_pkg::SLOT_W-1:0]    free_slot;

   assign rd_seq   = ram_rd_data[rrrb_pkg::SLOT_DATA_W-1 -: rrrb_pkg::SEQ_WIDTH];
   assign rd_size  = ram_rd_data[rrrb_pkg::TAG_WIDTH +: rrrb_pkg::SIZE_W];
   assign rd_tag   = ram_rd_data[rrrb_pkg::TAG_WIDTH-1:0];
   assign scan_end = (idx_ff == rrrb_pkg::SLOT_W'(rrrb_pkg::QUEUE_DEPTH - 1));

   always_comb begin
      case (mode_ff)
         rrrb_pkg::SC_DRAIN: hit = (rd_seq == exp_ff);
         rrrb_pkg::SC_STALE: hit = (rd_seq < exp_ff);
         default:            hit = 1'b1;
      endcase
   end

   always_comb begin
      free_slot = '0;
      for (int i = rrrb_pkg::QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = rrrb_pkg::SLOT_W'(i);
         end
      end
   end

   rrrb_ram #(
      .WIDTH(rrrb_pkg::SLOT_DATA_W),
      .DEPTH(rrrb_pkg::QUEUE_DEPTH)
   ) u_slots (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(q_head.slot),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(idx_ff),
      .rd_data(ram_rd_data)
   );

   assign ram_wr_data = {q_head.seq, q_head.size, q_head.tag};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrrb_pkg::B_IDLE: begin
            if (q_valid) begin
               if ((q_head.op == rrrb_pkg::OP_DELIVER) || (q_head.op == rrrb_pkg::OP_FIN)) begin
                  state_in = rrrb_pkg::B_ADDR;
               end else if (q_head.op == rrrb_pkg::OP_DISCARD_ACK) begin
                  state_in = rrrb_pkg::B_CLOSE;
               end
            end
         end
         rrrb_pkg::B_ADDR: begin
            if (valid_ff[idx_ff]) begin
               state_in = rrrb_pkg::B_DATA;
            end else if (scan_end && (mode_ff != rrrb_pkg::SC_DRAIN)) begin
               state_in = rrrb_pkg::B_CLOSE;
            end
         end
         rrrb_pkg::B_DATA: begin
            if (scan_end && (mode_ff != rrrb_pkg::SC_DRAIN) ) begin
               state_in = rrrb_pkg::B_CLOSE;
            end else begin
               state_in = rrrb_pkg::B_ADDR;
            end
         end
         rrrb_pkg::B_CLOSE: state_in = rrrb_pkg::B_IDLE;
         default:           state_in = rrrb_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      mode_in      = mode_ff;
      phase_in     = phase_ff;
      exp_in       = exp_ff;
      valid_in     = valid_ff;
      idx_in       = idx_ff;
      close_fin_in = close_fin_ff;
      rsp_in       = '0;
      pop          = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      case (state_ff)
         rrrb_pkg::B_IDLE: begin
            if (q_valid) begin
               pop = 1'b1;
               case (q_head.op)
                  rrrb_pkg::OP_SYNACK: begin
                     rsp_in.valid = 1'b1;
                     rsp_in.kind  = rrrb_pkg::K_SYNACK;
                     rsp_in.ack   = exp_ff;
                     rsp_in.last  = 1'b1;
                     phase_in     = rrrb_pkg::PH_DATA;
                  end
                  rrrb_pkg::OP_DISCARD_ONLY: begin
                     rsp_in.valid = 1'b1;
                     rsp_in.kind  = rrrb_pkg::K_DISCARD;
                     rsp_in.tag   = q_head.tag;
                     rsp_in.last  = 1'b1;
                  end
                  rrrb_pkg::OP_DISCARD_ACK: begin
                     rsp_in.valid = 1'b1;
                     rsp_in.kind  = rrrb_pkg::K_DISCARD;
                     rsp_in.tag   = q_head.tag;
                     rsp_in.ovf   = q_head.ovf;
                     close_fin_in = 1'b0;
                  end
                  rrrb_pkg::OP_STORE: begin
                     ram_wr_en              = 1'b1;
                     valid_in[q_head.slot]  = 1'b1;
                     rsp_in.valid           = 1'b1;
                     rsp_in.kind            = rrrb_pkg::K_ACK;
                     rsp_in.ack             = exp_ff;
                     rsp_in.last            = 1'b1;
                  end
                  rrrb_pkg::OP_DELIVER: begin
                     rsp_in.valid = 1'b1;
                     rsp_in.kind  = rrrb_pkg::K_DELIVER;
                     rsp_in.tag   = q_head.tag;
                     rsp_in.size  = q_head.size;
                     exp_in       = exp_ff + rrrb_pkg::SEQ_WIDTH'(q_head.size);
                     idx_in       = '0;
                     mode_in      = rrrb_pkg::SC_DRAIN;
                     close_fin_in = 1'b0;
                  end
                  rrrb_pkg::OP_FIN: begin
                     idx_in       = '0;
                     mode_in      = rrrb_pkg::SC_FIN;
                     close_fin_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         rrrb_pkg::B_ADDR: begin
            if (valid_ff[idx_ff]) begin
               ram_rd_en = 1'b1;
            end else if (scan_end) begin
               idx_in = '0;
               if (mode_ff == rrrb_pkg::SC_DRAIN) begin
                  mode_in = rrrb_pkg::SC_STALE;
               end
            end else begin
               idx_in = idx_ff + rrrb_pkg::SLOT_W'(1);
            end
         end
         rrrb_pkg::B_DATA: begin
            if (hit) begin
               valid_in[idx_ff] = 1'b0;
               rsp_in.valid     = 1'b1;
               rsp_in.tag       = rd_tag;
               if (mode_ff == rrrb_pkg::SC_DRAIN) begin
                  rsp_in.kind = rrrb_pkg::K_DELIVER;
                  rsp_in.size = rd_size;
                  exp_in      = exp_ff + rrrb_pkg::SEQ_WIDTH'(rd_size);
               end else begin
                  rsp_in.kind = rrrb_pkg::K_DISCARD;
               end
            end
            if (hit && (mode_ff == rrrb_pkg::SC_DRAIN)) begin
               idx_in = '0;
            end else if (scan_end) begin
               idx_in = '0;
               if (mode_ff == rrrb_pkg::SC_DRAIN) begin
                  mode_in = rrrb_pkg::SC_STALE;
               end
            end else begin
               idx_in = idx_ff + rrrb_pkg::SLOT_W'(1);
            end
         end
         rrrb_pkg::B_CLOSE: begin
            rsp_in.valid = 1'b1;
            rsp_in.ack   = exp_ff;
            rsp_in.last  = 1'b1;
            if (close_fin_ff) begin
               rsp_in.kind = rrrb_pkg::K_FINACK;
               phase_in    = rrrb_pkg::PH_DONE;
            end else begin
               rsp_in.kind = rrrb_pkg::K_ACK;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrrb_pkg::B_IDLE;
         mode_ff      <= rrrb_pkg::SC_DRAIN;
         phase_ff     <= rrrb_pkg::PH_WAIT;
         exp_ff       <= '0;
         valid_ff     <= '0;
         idx_ff       <= '0;
         close_fin_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         phase_ff     <= phase_in;
         exp_ff       <= exp_in;
         valid_ff     <= valid_in;
         idx_ff       <= idx_in;
         close_fin_ff <= close_fin_in;
         rsp_ff       <= rsp_in;
      end
   end

   assign status.phase     = phase_ff;
   assign status.expected  = exp_ff;
   assign status.full      = &valid_ff;
   assign status.free_slot = free_slot;
   assign status.busy      = (state_ff != rrrb_pkg::B_IDLE);
   assign rsp              = rsp_ff;

endmodule

@@ src/reliable_receiver_reorder_buffer_top.sv @@
// Top level of the reorder buffer receiver: front end, command queue and back end.
//
//   channel   ports                         handshake
//   request   req_cmd/seq_number/size/tag   start high and busy low
//   response  rsp_kind/ack/tag/size/ovf/last rsp_valid only, no ready
//
// A packet is registered in the front end, queued, then run by the back end.
// Simple packets need no slot walk; a delivery or FIN walks the 16 slots, each in B_ADDR
// and a valid one also in B_DATA through the slot RAM read port, restarting after each drain hit.
// Reset is synchronous and clears the phase, the expected index and all slot valid bits.
// busy stays high until the last response beat of a packet has been issued.
// The response side cannot stall; each beat is shown for exactly one cycle.
module reliable_receiver_reorder_buffer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [rrrb_pkg::CMD_W-1:0]     req_cmd,
   input  logic [rrrb_pkg::SEQ_WIDTH-1:0] req_seq_number,
   input  logic [rrrb_pkg::SIZE_W-1:0]    req_payload_size,
   input  logic [rrrb_pkg::TAG_WIDTH-1:0] req_payload_tag,
   output logic                           rsp_valid,
   output logic [rrrb_pkg::KIND_W-1:0]    rsp_kind,
   output logic [rrrb_pkg::SEQ_WIDTH-1:0] rsp_ack_number,
   output logic [rrrb_pkg::TAG_WIDTH-1:0] rsp_out_tag,
   output logic [rrrb_pkg::SIZE_W-1:0]    rsp_out_size,
   output logic                           rsp_overflow,
   output logic                           rsp_last
);

`include "reliable_receiver_reorder_buffer_top_assert.svh"

   logic                 accept;
   logic                 push;
   logic                 pop;
   logic                 q_valid;
   logic                 front_busy;
   rrrb_pkg::entry_type  push_entry;
   rrrb_pkg::entry_type  q_head;
   rrrb_pkg::status_type status;
   rrrb_pkg::rsp_type    rsp;

   assign accept = start && !busy;
   assign busy   = front_busy || q_valid || status.busy;

   rrrb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cmd         (req_cmd),
      .seq_number  (req_seq_number),
      .payload_size(req_payload_size),
      .payload_tag (req_payload_tag),
      .status      (status),
      .push        (push),
      .entry       (push_entry),
      .busy        (front_busy)
   );

   rrrb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .not_empty (q_valid),
      .head      (q_head)
   );

   rrrb_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_valid(q_valid),
      .q_head (q_head),
      .pop    (pop),
      .status (status),
      .rsp    (rsp)
   );

   assign rsp_valid      = rsp.valid;
   assign rsp_kind       = rsp.kind;
   assign rsp_ack_number = rsp.ack;
   assign rsp_out_tag    = rsp.tag;
   assign rsp_out_size   = rsp.size;
   assign rsp_overflow   = rsp.ovf;
   assign rsp_last       = rsp.last;

   `RRRB_ASSERT(a_accept_busy, (start && !busy) |=> busy, "busy low after an accepted beat")
   `RRRB_ASSERT_ALWAYS(a_last_valid, rsp_last |-> rsp_valid, "last flag without a response")
   `RRRB_ASSERT(a_ovf_discard, rsp_overflow |-> (rsp_kind == rrrb_pkg::K_DISCARD), "overflow on non-discard")

endmodule
